// File: rtl/core/assert_macros.svh
// Assertion macros used by the core controller.
// Defines clocked assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/cmpc_pkg.sv
// Shared types and constants for the convex mesh point containment core.
// No dependencies; used by the controller, the datapath and the top level.
package cmpc_pkg;

	// Coordinate and arithmetic widths
	localparam int COORD_WIDTH = 20;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int NORM_WIDTH  = PROD_WIDTH + 1;
	localparam int DOT_WIDTH   = NORM_WIDTH + DIFF_WIDTH;
	localparam int SUM_WIDTH   = DOT_WIDTH + 2;

	// Configuration register indexes
	localparam int CFG_IDX_WIDTH = 2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_X = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_Y = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_Z = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic xprod;
		logic norm;
		logic dot;
		logic fin;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_face;
	} dp_sts_t;

endpackage

// File: rtl/core/cmpc_ctrl.sv
// Sequencing controller for the containment core.
// Depends on cmpc_pkg and assert_macros.svh; drives datapath commands and handshakes.
`include "assert_macros.svh"
module cmpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              face_valid,
	output logic              face_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  cmpc_pkg::dp_sts_t sts,
	output cmpc_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CROSS = 3'd1;
	localparam logic [2:0] ST_NORM  = 3'd2;
	localparam logic [2:0] ST_DOT   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       fin_go;
	logic       accept;

	// Finish a face once a result slot is free (only the last face needs one)
	assign out_free   = !out_valid_q || !res_stall;
	assign fin_go     = (state_q == ST_FIN) && (!sts.last_face || out_free);
	assign face_stall = !((state_q == ST_IDLE) || fin_go);
	assign accept     = face_valid && !face_stall;
	assign res_valid  = out_valid_q;

	// Issue datapath commands
	always_comb begin
		cmd.load  = accept;
		cmd.xprod = (state_q == ST_CROSS);
		cmd.norm  = (state_q == ST_NORM);
		cmd.dot   = (state_q == ST_DOT);
		cmd.fin   = fin_go;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  state_nxt = accept ? ST_CROSS : ST_IDLE;
			ST_CROSS: state_nxt = ST_NORM;
			ST_NORM:  state_nxt = ST_DOT;
			ST_DOT:   state_nxt = ST_FIN;
			ST_FIN: begin
				if (fin_go) begin
					state_nxt = accept ? ST_CROSS : ST_IDLE;
				end
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Advance state and hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fin_go && sts.last_face) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_CLK(a_accept_state, clk, arst_n, accept |-> (state_q == ST_IDLE || state_q == ST_FIN), "face accepted while busy")
	`ASSERT_CLK(a_last_emits, clk, arst_n, (fin_go && sts.last_face) |=> out_valid_q, "last face produced no result")
	`ASSERT_CLK(a_cross_to_norm, clk, arst_n, (state_q == ST_CROSS) |=> (state_q == ST_NORM), "cross step did not advance")
	`ASSERT_ALWAYS(a_cmd_onehot, clk, $onehot0({cmd.xprod, cmd.norm, cmd.dot, cmd.fin}), "overlapping datapath steps")

endmodule

// File: rtl/core/cmpc_dpath.sv
// Arithmetic datapath: edge vectors, face normal, dot product and inside flag.
// Depends on cmpc_pkg; steered by cmpc_ctrl through dp_cmd_t.
module cmpc_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cmpc_pkg::dp_cmd_t                      cmd,
	output cmpc_pkg::dp_sts_t                      sts,
	input  logic                                   cfg_we,
	input  logic [cmpc_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] cfg_data,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_z,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_z,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_z,
	input  logic                                   last_face,
	output logic                                   inside_res
);

	localparam int CW = cmpc_pkg::COORD_WIDTH;
	localparam int DW = cmpc_pkg::DIFF_WIDTH;
	localparam int PW = cmpc_pkg::PROD_WIDTH;
	localparam int NW = cmpc_pkg::NORM_WIDTH;
	localparam int XW = cmpc_pkg::DOT_WIDTH;
	localparam int SW = cmpc_pkg::SUM_WIDTH;

	logic signed [CW-1:0] point_x_q, point_y_q, point_z_q;
	logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, qx_q, qy_q, qz_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
	logic signed [NW-1:0] nx_q, ny_q, nz_q;
	logic signed [XW-1:0] dx_q, dy_q, dz_q;
	logic signed [SW-1:0] dsum;
	logic                 d_pos;
	logic                 face_ok;
	logic                 last_q;
	logic                 all_pos_q;
	logic                 inside_q;

	// Write the query point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			point_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmpc_pkg::REG_POINT_X: point_x_q <= cfg_data;
				cmpc_pkg::REG_POINT_Y: point_y_q <= cfg_data;
				cmpc_pkg::REG_POINT_Z: point_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load edge vectors and point offset on a new face
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ux_q   <= DW'(b_x) - DW'(a_x);
			uy_q   <= DW'(b_y) - DW'(a_y);
			uz_q   <= DW'(b_z) - DW'(a_z);
			vx_q   <= DW'(c_x) - DW'(a_x);
			vy_q   <= DW'(c_y) - DW'(a_y);
			vz_q   <= DW'(c_z) - DW'(a_z);
			qx_q   <= DW'(point_x_q) - DW'(a_x);
			qy_q   <= DW'(point_y_q) - DW'(a_y);
			qz_q   <= DW'(point_z_q) - DW'(a_z);
			last_q <= last_face;
		end
	end

	// Cross product partial terms
	always_ff @(posedge clk) begin
		if (cmd.xprod) begin
			p0_q <= PW'(uy_q * vz_q);
			p1_q <= PW'(uz_q * vy_q);
			p2_q <= PW'(uz_q * vx_q);
			p3_q <= PW'(ux_q * vz_q);
			p4_q <= PW'(ux_q * vy_q);
			p5_q <= PW'(uy_q * vx_q);
		end
	end

	// Face normal
	always_ff @(posedge clk) begin
		if (cmd.norm) begin
			nx_q <= NW'(p0_q) - NW'(p1_q);
			ny_q <= NW'(p2_q) - NW'(p3_q);
			nz_q <= NW'(p4_q) - NW'(p5_q);
		end
	end

	// Dot product terms
	always_ff @(posedge clk) begin
		if (cmd.dot) begin
			dx_q <= XW'(nx_q * qx_q);
			dy_q <= XW'(ny_q * qy_q);
			dz_q <= XW'(nz_q * qz_q);
		end
	end

	// Sum and take the sign
	assign dsum    = SW'(dx_q) + SW'(dy_q) + SW'(dz_q);
	assign d_pos   = !dsum[SW-1] && (dsum != '0);
	assign face_ok = all_pos_q && d_pos;

	// Update the sticky flag; report and rearm it on the last face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_pos_q <= 1'b1;
		end else if (cmd.fin) begin
			all_pos_q <= last_q ? 1'b1 : face_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && last_q) begin
			inside_q <= face_ok;
		end
	end

	assign inside_res    = inside_q;
	assign sts.last_face = last_q;

endmodule

// File: rtl/core/convex_mesh_point_containment.sv
// Top level of the convex mesh point containment core.
// Depends on cmpc_pkg, cmpc_ctrl and cmpc_dpath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  face in  | face_valid / face_stall  | a_*, b_*, c_* (20b signed), last_face
//  result   | res_valid / res_stall    | inside_res
//  config   | cfg_valid / cfg_ready    | cfg_index (2b), cfg_data (20b signed)
//
// Each face passes through edge load, six cross-product multiplies, normal
// subtract and three dot-product multiplies; the sum and sign check overlap the
// load of the next face.
// Reset clears the query point to zero and the sticky all-positive flag to one.
// A stalled result holds only the final step of a last face; other faces pass.
// The config port is always ready; index 3 is ignored.
module convex_mesh_point_containment (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cmpc_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] cfg_data,
	input  logic                                    face_valid,
	output logic                                    face_stall,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] a_z,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] b_z,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_x,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_y,
	input  logic signed [cmpc_pkg::COORD_WIDTH-1:0] c_z,
	input  logic                                    last_face,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output logic                                    inside_res
);

	cmpc_pkg::dp_cmd_t cmd;
	cmpc_pkg::dp_sts_t sts;

	// Accept every config transaction
	assign cfg_ready = 1'b1;

	cmpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	cmpc_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.c_x        (c_x),
		.c_y        (c_y),
		.c_z        (c_z),
		.last_face  (last_face),
		.inside_res (inside_res)
	);

endmodule
